### rtl/hlp_pkg.sv
package hlp_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 10;
    localparam int KIND_W = 3;
    localparam int STAT_W = 2;

    // Decode buffer size; bytes kept per string are capped one below it.
    localparam int STR_BUF_BYTES = 1024;
    localparam int LEN_MAX       = (1 << LEN_W) - 1;
    localparam logic [LEN_W-1:0] LEN_CAP =
        (STR_BUF_BYTES - 1 > LEN_MAX) ? LEN_W'(LEN_MAX) : LEN_W'(STR_BUF_BYTES - 1);

    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 10'd1023;

    // Result queue depth; at most two results per input transfer.
    localparam int FIFO_DEPTH = 4;

    localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
    localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_N      = 8'h6E;
    localparam logic [BYTE_W-1:0] CH_T      = 8'h74;
    localparam logic [BYTE_W-1:0] CH_R      = 8'h72;
    localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
    localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;

    typedef enum logic [KIND_W-1:0] {
        KIND_KEY_BYTE = 3'd0,
        KIND_VAL_BYTE = 3'd1,
        KIND_KEY_END  = 3'd2,
        KIND_PAIR_END = 3'd3,
        KIND_STATUS   = 3'd4
    } kind_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_LIT   = 2'd1,
        ST_TRUNCATED = 2'd2,
        ST_OVERLONG  = 2'd3
    } status_t;

    typedef struct packed {
        kind_t              kind;
        logic [BYTE_W-1:0]  data;
        status_t            status;
        logic               run_last;
    } result_t;

    // Results of one input transfer, packed from slot 0 upward.
    typedef struct packed {
        logic    v0;
        logic    v1;
        result_t r0;
        result_t r1;
    } step_t;

endpackage

### rtl/hlp_parser.sv
module hlp_parser (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic [hlp_pkg::BYTE_W-1:0] in_byte,
    input  logic                       in_last,
    input  logic [hlp_pkg::LEN_W-1:0]  max_len,
    output hlp_pkg::step_t             step
);
    import hlp_pkg::*;

    typedef enum logic [8:0] {
        PH_START    = 9'b000000001,
        PH_DEAD     = 9'b000000010,
        PH_SEEK_KEY = 9'b000000100,
        PH_KEY      = 9'b000001000,
        PH_KEY_ESC  = 9'b000010000,
        PH_KEY_GAP  = 9'b000100000,
        PH_SEEK_VAL = 9'b001000000,
        PH_VAL      = 9'b010000000,
        PH_VAL_ESC  = 9'b100000000
    } phase_t;

    phase_t             phase_reg, phase_next, phase_mid;
    logic [LEN_W-1:0]   len_reg, len_next, len_mid;
    logic               ovl_reg, ovl_next, ovl_mid;
    logic [LEN_W-1:0]   limit;
    logic               is_quote, is_bslash;
    logic               data_req;
    logic               d_valid;
    kind_t              d_kind;
    logic [BYTE_W-1:0]  d_byte;
    status_t            st;
    result_t            res_d, res_s;

    function automatic logic [BYTE_W-1:0] unescape(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] r;
        r = b;
        if (b == CH_N)
            r = CH_LF;
        else if (b == CH_T)
            r = CH_TAB;
        else if (b == CH_R)
            r = CH_CR;
        return r;
    endfunction

    assign limit     = (LEN_CAP < max_len) ? LEN_CAP : max_len;
    assign is_quote  = (in_byte == CH_QUOTE);
    assign is_bslash = (in_byte == CH_BSLASH);

    always_comb
    begin
        phase_mid = phase_reg;
        len_mid   = len_reg;
        ovl_mid   = ovl_reg;
        data_req  = 1'b0;
        d_valid   = 1'b0;
        d_kind    = KIND_KEY_BYTE;
        d_byte    = '0;
        unique case (phase_reg)
            PH_DEAD:
            begin
            end
            PH_SEEK_KEY:
            begin
                if (is_quote)
                begin
                    phase_mid = PH_KEY;
                    len_mid   = '0;
                end
            end
            PH_KEY:
            begin
                if (is_bslash)
                    phase_mid = PH_KEY_ESC;
                else if (is_quote)
                begin
                    d_valid   = 1'b1;
                    d_kind    = KIND_KEY_END;
                    phase_mid = PH_KEY_GAP;
                end
                else
                begin
                    data_req = 1'b1;
                    d_kind   = KIND_KEY_BYTE;
                    d_byte   = in_byte;
                end
            end
            PH_KEY_ESC:
            begin
                data_req  = 1'b1;
                d_kind    = KIND_KEY_BYTE;
                d_byte    = unescape(in_byte);
                phase_mid = PH_KEY;
            end
            PH_KEY_GAP:
                phase_mid = PH_SEEK_VAL;
            PH_SEEK_VAL:
            begin
                if (is_quote)
                begin
                    phase_mid = PH_VAL;
                    len_mid   = '0;
                end
            end
            PH_VAL:
            begin
                if (is_bslash)
                    phase_mid = PH_VAL_ESC;
                else if (is_quote)
                begin
                    d_valid   = 1'b1;
                    d_kind    = KIND_PAIR_END;
                    phase_mid = PH_SEEK_KEY;
                end
                else
                begin
                    data_req = 1'b1;
                    d_kind   = KIND_VAL_BYTE;
                    d_byte   = in_byte;
                end
            end
            PH_VAL_ESC:
            begin
                data_req  = 1'b1;
                d_kind    = KIND_VAL_BYTE;
                d_byte    = unescape(in_byte);
                phase_mid = PH_VAL;
            end
            default:
            begin
                // start of literal, and any stray code
                if (is_quote)
                begin
                    phase_mid = PH_KEY;
                    len_mid   = '0;
                end
                else
                    phase_mid = PH_DEAD;
            end
        endcase

        // over the limit: drop the byte, remember it
        if (data_req)
        begin
            if (len_reg >= limit)
                ovl_mid = 1'b1;
            else
            begin
                len_mid = len_reg + 1'b1;
                d_valid = 1'b1;
            end
        end
    end

    always_comb
    begin
        priority if (phase_mid == PH_DEAD || phase_mid == PH_START)
            st = ST_NOT_LIT;
        else if (phase_mid != PH_SEEK_KEY)
            st = ST_TRUNCATED;
        else if (ovl_mid)
            st = ST_OVERLONG;
        else
            st = ST_OK;
    end

    always_comb
    begin
        res_d.kind     = d_kind;
        res_d.data     = d_byte;
        res_d.status   = ST_OK;
        res_d.run_last = ~in_last;
        res_s.kind     = KIND_STATUS;
        res_s.data     = '0;
        res_s.status   = st;
        res_s.run_last = 1'b1;

        step.v0 = accept & (d_valid | in_last);
        step.v1 = accept & d_valid & in_last;
        step.r0 = d_valid ? res_d : res_s;
        step.r1 = res_s;
    end

    always_comb
    begin
        if (in_last)
        begin
            phase_next = PH_START;
            len_next   = '0;
            ovl_next   = 1'b0;
        end
        else
        begin
            phase_next = phase_mid;
            len_next   = len_mid;
            ovl_next   = ovl_mid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            len_reg   <= '0;
            ovl_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            ovl_reg   <= ovl_next;
        end
    end

endmodule

### rtl/hlp_out_fifo.sv
module hlp_out_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  hlp_pkg::step_t   step,
    output logic             room,
    output logic             out_valid,
    input  logic             out_ready,
    output hlp_pkg::result_t head
);
    import hlp_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    result_t            mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]   wr_ptr_p1;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   n_push;
    logic               pop;

    assign room      = (cnt_reg <= CNT_W'(FIFO_DEPTH - 2));
    assign out_valid = (cnt_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];
    assign pop       = out_valid & out_ready;
    assign wr_ptr_p1 = wr_ptr_reg + 1'b1;
    assign n_push    = CNT_W'(step.v0) + CNT_W'(step.v1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(n_push);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        cnt_next    = cnt_reg + n_push - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (step.v0)
            mem_reg[wr_ptr_reg] <= step.r0;
        if (step.v1)
            mem_reg[wr_ptr_p1] <= step.r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

### rtl/hstore_literal_parser.sv
// hstore_literal_parser: streaming decoder for key/value store literals.
//
// Input channel (in_valid/in_ready, in_byte, in_last): one literal byte per
// transfer; in_last flags the final byte of a literal.
// Output channel (out_valid/out_ready): one result per transfer. Kinds are
// key byte, value byte, key end, pair end and a literal status that closes
// every literal; out_run_last marks the final result of one input byte.
// Config channel (cfg_valid/cfg_ready, cfg_data): writes max_len, always
// ready. Write only while the block is idle.
//
// Results are registered in the result FIFO and offered from its head.
// Throughput: one input byte per cycle. A byte yields at most two results
// (a data or mark result plus the status on in_last), which are queued in a
// four-entry result FIFO; in_ready drops while fewer than two slots are free,
// so sustained rate is set by the output drain of one result per cycle.
// A stalled receiver fills the FIFO and then holds off input; nothing drops.
// Reset: parser back to start, FIFO empty, max_len to 1023.
module hstore_literal_parser (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [hlp_pkg::BYTE_W-1:0] in_byte,
    input  logic                       in_last,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [hlp_pkg::KIND_W-1:0] out_kind,
    output logic [hlp_pkg::BYTE_W-1:0] out_byte,
    output logic [hlp_pkg::STAT_W-1:0] out_status,
    output logic                       out_run_last,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [hlp_pkg::LEN_W-1:0]  cfg_data
);
    import hlp_pkg::*;

    logic [LEN_W-1:0]  max_len_reg;
    logic              accept;
    logic              room;
    step_t             step;
    result_t           head;

    // max_len register; cfg_ready is tied high, so every write is taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_len_reg <= MAX_LEN_RESET;
        else if (cfg_valid)
            max_len_reg <= cfg_data;
    end

    // take a byte only when both of its possible results fit
    assign in_ready = room;
    assign accept   = in_valid & in_ready;

    hlp_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (in_byte),
        .in_last (in_last),
        .max_len (max_len_reg),
        .step    (step)
    );

    hlp_out_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign out_kind     = head.kind;
    assign out_byte     = head.data;
    assign out_status   = head.status;
    assign out_run_last = head.run_last;

endmodule

### rtl/hlp_checker.sv
module hlp_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [hlp_pkg::KIND_W-1:0] out_kind,
    input logic [hlp_pkg::BYTE_W-1:0] out_byte,
    input logic [hlp_pkg::STAT_W-1:0] out_status,
    input logic                       out_run_last
);
    import hlp_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_kind)
            && $stable(out_byte) && $stable(out_status) && $stable(out_run_last))
        else $error("stalled result changed");

    // status closes the run of results of its byte
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind == KIND_STATUS |-> out_run_last)
        else $error("status without run_last");

    // status field only on status results
    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind != KIND_STATUS |-> out_status == '0)
        else $error("status set on non-status result");

    // marks carry no byte
    a_mark_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_kind == KIND_KEY_END || out_kind == KIND_PAIR_END
            || out_kind == KIND_STATUS) |-> out_byte == '0)
        else $error("mark carries data");

    // a result only appears after some input transfer
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid ##1 out_valid |-> $past(in_valid && in_ready))
        else $error("result without input");

endmodule

bind hstore_literal_parser hlp_checker u_hlp_checker (.*);

### bench/hstore_literal_parser_tb.sv
`timescale 1ns / 1ps

module hstore_literal_parser_tb;

    import hlp_pkg::*;

    // Cycles with no transfer on any channel before the run is given up.
    localparam int QUIET_LIMIT  = 2000;
    // Quiet cycles after the last result, to catch anything extra.
    localparam int TAIL_CYCLES  = 10;
    // Random literal bytes per config phase, counting only non-noise literals.
    localparam int PHASE_ITEMS  = 100;
    localparam int NUM_PHASES   = 8;
    // Decoded length of the one oversized key; crosses the buffer cap.
    localparam int BIG_KEY_LEN  = 1025;

    // Parser position, mirrored by the predictor.
    typedef enum logic [3:0] {
        LX_START,
        LX_DEAD,
        LX_SEEK_KEY,
        LX_KEY,
        LX_KEY_ESC,
        LX_KEY_GAP,
        LX_SEEK_VAL,
        LX_VAL,
        LX_VAL_ESC
    } lex_phase_t;

    typedef enum logic {
        ROW_BYTE,
        ROW_CFG
    } row_op_t;

    // One line of the directed table: a literal byte or a max_len write.
    // Rows marked typed carry their single expected result inline.
    typedef struct {
        row_op_t          op;
        logic [LEN_W-1:0] cfg_val;
        logic [7:0]       text_byte;
        logic             last;
        bit               typed;
        result_t          want;
    } stim_row_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [BYTE_W-1:0] in_byte;
    logic              in_last;
    logic              out_valid;
    logic              out_ready;
    logic [KIND_W-1:0] out_kind;
    logic [BYTE_W-1:0] out_byte;
    logic [STAT_W-1:0] out_status;
    logic              out_run_last;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [LEN_W-1:0]  cfg_data;

    // Predictor state: parser position, current string length, drop flag,
    // and the shadow of max_len.
    lex_phase_t        lex_phase  = LX_START;
    logic [LEN_W-1:0]  str_len    = '0;
    logic              overlong   = 1'b0;
    logic [LEN_W-1:0]  keep_limit = MAX_LEN_RESET;

    result_t           byte_results[$];     // results of the byte just decoded
    result_t           decoded_results[$];  // results still owed by the block
    logic [7:0]        literal_text[$];     // random literal being built
    stim_row_t         stim_rows[$];

    int                send_idle_pct  = 0;
    int                recv_stall_pct = 0;
    int                mismatch_count = 0;
    int                quiet_cycles   = 0;

    hstore_literal_parser dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_byte      (in_byte),
        .in_last      (in_last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_kind     (out_kind),
        .out_byte     (out_byte),
        .out_status   (out_status),
        .out_run_last (out_run_last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic void emit(kind_t k, logic [7:0] d, status_t s);
        result_t r;
        r.kind     = k;
        r.data     = d;
        r.status   = s;
        r.run_last = 1'b0;
        byte_results = {byte_results, r};
    endfunction

    // Decoded byte: kept while under both max_len and the buffer cap,
    // otherwise silently dropped and remembered for the status.
    function automatic void keep_decoded(kind_t k, logic [7:0] d);
        logic [LEN_W-1:0] limit;
        limit = (keep_limit < LEN_CAP) ? keep_limit : LEN_CAP;
        if (str_len >= limit)
        begin
            overlong = 1'b1;
        end
        else
        begin
            str_len = str_len + 1'b1;
            emit(k, d, ST_OK);
        end
    endfunction

    function automatic logic [7:0] unescaped(logic [7:0] b);
        case (b)
            CH_N:    return CH_LF;
            CH_T:    return CH_TAB;
            CH_R:    return CH_CR;
            default: return b;
        endcase
    endfunction

    // Advance the shadow parser by one literal byte; results land in
    // byte_results with run_last on the final one.
    function automatic void decode_literal_byte(logic [7:0] b, logic last);
        status_t st;
        byte_results.delete();
        case (lex_phase)
            LX_DEAD:
            begin
            end
            LX_SEEK_KEY:
            begin
                if (b == CH_QUOTE)
                begin
                    lex_phase = LX_KEY;
                    str_len   = '0;
                end
            end
            LX_KEY:
            begin
                if (b == CH_BSLASH)
                begin
                    lex_phase = LX_KEY_ESC;
                end
                else if (b == CH_QUOTE)
                begin
                    emit(KIND_KEY_END, 8'h00, ST_OK);
                    lex_phase = LX_KEY_GAP;
                end
                else
                begin
                    keep_decoded(KIND_KEY_BYTE, b);
                end
            end
            LX_KEY_ESC:
            begin
                keep_decoded(KIND_KEY_BYTE, unescaped(b));
                lex_phase = LX_KEY;
            end
            // the byte right after a key's closing quote is eaten whatever it is
            LX_KEY_GAP:
            begin
                lex_phase = LX_SEEK_VAL;
            end
            LX_SEEK_VAL:
            begin
                if (b == CH_QUOTE)
                begin
                    lex_phase = LX_VAL;
                    str_len   = '0;
                end
            end
            LX_VAL:
            begin
                if (b == CH_BSLASH)
                begin
                    lex_phase = LX_VAL_ESC;
                end
                else if (b == CH_QUOTE)
                begin
                    emit(KIND_PAIR_END, 8'h00, ST_OK);
                    lex_phase = LX_SEEK_KEY;
                end
                else
                begin
                    keep_decoded(KIND_VAL_BYTE, b);
                end
            end
            LX_VAL_ESC:
            begin
                keep_decoded(KIND_VAL_BYTE, unescaped(b));
                lex_phase = LX_VAL;
            end
            default:
            begin
                if (b == CH_QUOTE)
                begin
                    lex_phase = LX_KEY;
                    str_len   = '0;
                end
                else
                begin
                    lex_phase = LX_DEAD;
                end
            end
        endcase

        if (last)
        begin
            // not-a-literal beats truncated beats overlong beats ok
            if (lex_phase == LX_DEAD || lex_phase == LX_START)
                st = ST_NOT_LIT;
            else if (lex_phase != LX_SEEK_KEY)
                st = ST_TRUNCATED;
            else if (overlong)
                st = ST_OVERLONG;
            else
                st = ST_OK;
            emit(KIND_STATUS, 8'h00, st);
            lex_phase = LX_START;
            str_len   = '0;
            overlong  = 1'b0;
        end

        if (byte_results.size() > 0)
            byte_results[byte_results.size() - 1].run_last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Drivers. Inputs move on the falling edge; handshakes are judged on
    // the rising edge.
    // ------------------------------------------------------------------

    // One input transfer. Returns right after the accepting edge, so the
    // next call decides at the coming falling edge whether valid drops.
    task automatic send_byte(logic [7:0] b, logic last, bit typed, result_t want);
        @(negedge clk);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        in_last  <= last;
        do
            @(posedge clk);
        while (!in_ready);
        decode_literal_byte(b, last);
        if (typed)
            decoded_results = {decoded_results, want};
        else
            foreach (byte_results[i])
                decoded_results = {decoded_results, byte_results[i]};
    endtask

    // Drop valid and wait for every owed result to come out.
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (decoded_results.size() != 0)
            @(posedge clk);
    endtask

    // max_len is only touched with the parser idle. A byte can leave no
    // result, so idle cycles after the drain let the registered parser settle.
    task automatic write_max_len(logic [LEN_W-1:0] v);
        drain_results();
        repeat (4) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        keep_limit = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Directed table helpers
    // ------------------------------------------------------------------

    function automatic stim_row_t byte_row(logic [7:0] b, logic last);
        stim_row_t row;
        row.op        = ROW_BYTE;
        row.cfg_val   = '0;
        row.text_byte = b;
        row.last      = last;
        row.typed     = 1'b0;
        row.want      = '0;
        return row;
    endfunction

    function automatic stim_row_t typed_row(logic [7:0] b, logic last, kind_t k,
                                            logic [7:0] d, status_t s);
        stim_row_t row;
        row = byte_row(b, last);
        row.typed         = 1'b1;
        row.want.kind     = k;
        row.want.data     = d;
        row.want.status   = s;
        row.want.run_last = 1'b1;
        return row;
    endfunction

    function automatic stim_row_t cfg_row(logic [LEN_W-1:0] v);
        stim_row_t row;
        row = byte_row(8'h00, 1'b0);
        row.op      = ROW_CFG;
        row.cfg_val = v;
        return row;
    endfunction

    function automatic void add_row(stim_row_t row);
        stim_rows = {stim_rows, row};
    endfunction

    // ------------------------------------------------------------------
    // Random literal builder
    // ------------------------------------------------------------------

    function automatic void put_text(logic [7:0] c);
        literal_text = {literal_text, c};
    endfunction

    // Any byte that does not open or close a string.
    function automatic logic [7:0] filler_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(255, 1));
        while (c == CH_QUOTE);
        return c;
    endfunction

    function automatic void add_filler(int n);
        repeat (n)
            put_text(filler_byte());
    endfunction

    // Quoted string of len decoded bytes, about one in eight escaped.
    function automatic void add_string(int len);
        logic [7:0] c;
        put_text(CH_QUOTE);
        repeat (len)
        begin
            if ($urandom_range(7) == 0)
            begin
                put_text(CH_BSLASH);
                case ($urandom_range(5))
                    0:       put_text(CH_N);
                    1:       put_text(CH_T);
                    2:       put_text(CH_R);
                    3:       put_text(CH_QUOTE);
                    4:       put_text(CH_BSLASH);
                    default: put_text(8'($urandom_range(255, 1)));
                endcase
            end
            else
            begin
                do
                    c = 8'($urandom_range(255, 1));
                while (c == CH_QUOTE || c == CH_BSLASH);
                put_text(c);
            end
        end
        put_text(CH_QUOTE);
    endfunction

    // Mostly short strings, now and then long enough to hit small limits.
    function automatic int pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return $urandom_range(4);
        else if (r < 95)
            return $urandom_range(12, 5);
        else
            return $urandom_range(40, 13);
    endfunction

    // Builds and sends one literal. About 72% well formed, 20% cut short
    // at a random byte, 8% plain noise. Returns bytes sent, noise excluded.
    task automatic send_random_literal(bit big, output int counted);
        int shape;
        int npairs;
        int cut;
        shape = big ? 50 : $urandom_range(99);
        literal_text.delete();
        if (shape < 8)
        begin
            repeat ($urandom_range(8, 1))
                put_text(8'($urandom_range(255, 1)));
        end
        else
        begin
            npairs = $urandom_range(4, 1);
            for (int p = 0; p < npairs; p++)
            begin
                if (p > 0)
                    add_filler($urandom_range(3));
                add_string((big && p == 0) ? BIG_KEY_LEN : pick_len());
                // gap byte may be anything, a quote included
                put_text(8'($urandom_range(255, 1)));
                add_filler($urandom_range(2));
                add_string(pick_len());
            end
            add_filler($urandom_range(2));
            if (shape < 28)
            begin
                cut = $urandom_range(literal_text.size(), 1);
                while (literal_text.size() > cut)
                    void'(literal_text.pop_back());
            end
        end
        foreach (literal_text[i])
            send_byte(literal_text[i], i == literal_text.size() - 1, 1'b0, '0);
        counted = (shape < 8) ? 0 : literal_text.size();
    endtask

    // ------------------------------------------------------------------
    // Receiver: out_ready toggles on the falling edge per the stall rate.
    // ------------------------------------------------------------------
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    // ------------------------------------------------------------------
    // Result checker: each output transfer against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (decoded_results.size() == 0)
            begin
                $error("result with nothing owed: kind %0d byte %02h status %0d last %0d",
                       out_kind, out_byte, out_status, out_run_last);
                mismatch_count++;
            end
            else
            begin
                want = decoded_results.pop_front();
                if (out_kind !== want.kind)
                begin
                    $error("out_kind: expected %0d, got %0d", want.kind, out_kind);
                    mismatch_count++;
                end
                if (out_byte !== want.data)
                begin
                    $error("out_byte: expected %02h, got %02h", want.data, out_byte);
                    mismatch_count++;
                end
                if (out_status !== want.status)
                begin
                    $error("out_status: expected %0d, got %0d", want.status, out_status);
                    mismatch_count++;
                end
                if (out_run_last !== want.run_last)
                begin
                    $error("out_run_last: expected %0d, got %0d",
                           want.run_last, out_run_last);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too long without any transfer means the block hung.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Widest max_len the register holds.
    function automatic logic [LEN_W-1:0] LEN_MAX_RESET_VAL();
        return LEN_W'(LEN_MAX);
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic [LEN_W-1:0] len_plan [NUM_PHASES];
        logic [LEN_W-1:0] next_len;
        int               phase_items;
        int               sent;

        in_valid  = 1'b0;
        in_byte   = '0;
        in_last   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        rst_n     = 1'b0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, run at the reset max_len and then at zero and one.
        // Non-literal first byte; lone opening quote ends as truncated.
        add_row(typed_row(8'h78, 1'b1, KIND_STATUS, 8'h00, ST_NOT_LIT));
        add_row(typed_row(CH_QUOTE, 1'b1, KIND_STATUS, 8'h00, ST_TRUNCATED));
        // Key with escaped newline and escaped quote.
        add_row(byte_row(CH_QUOTE, 1'b0));
        add_row(typed_row(8'h6B, 1'b0, KIND_KEY_BYTE, 8'h6B, ST_OK));
        add_row(byte_row(CH_BSLASH, 1'b0));
        add_row(typed_row(CH_N, 1'b0, KIND_KEY_BYTE, CH_LF, ST_OK));
        add_row(byte_row(CH_BSLASH, 1'b0));
        add_row(typed_row(CH_QUOTE, 1'b0, KIND_KEY_BYTE, CH_QUOTE, ST_OK));
        add_row(typed_row(CH_QUOTE, 1'b0, KIND_KEY_END, 8'h00, ST_OK));
        // Gap byte is a quote and must still be skipped.
        add_row(byte_row(CH_QUOTE, 1'b0));
        add_row(byte_row(CH_QUOTE, 1'b0));
        // Value: zero byte, all-ones byte, escaped tab and CR.
        add_row(typed_row(8'h00, 1'b0, KIND_VAL_BYTE, 8'h00, ST_OK));
        add_row(typed_row(8'hFF, 1'b0, KIND_VAL_BYTE, 8'hFF, ST_OK));
        add_row(byte_row(CH_BSLASH, 1'b0));
        add_row(typed_row(CH_T, 1'b0, KIND_VAL_BYTE, CH_TAB, ST_OK));
        add_row(byte_row(CH_BSLASH, 1'b0));
        add_row(typed_row(CH_R, 1'b0, KIND_VAL_BYTE, CH_CR, ST_OK));
        add_row(typed_row(CH_QUOTE, 1'b0, KIND_PAIR_END, 8'h00, ST_OK));
        add_row(typed_row(8'h2C, 1'b1, KIND_STATUS, 8'h00, ST_OK));
        // Zero max_len: key byte dropped, pair end and overlong on one byte.
        add_row(cfg_row('0));
        add_row(byte_row(CH_QUOTE, 1'b0));
        add_row(byte_row(8'h61, 1'b0));
        add_row(byte_row(CH_QUOTE, 1'b0));
        add_row(byte_row(8'h3D, 1'b0));
        add_row(byte_row(CH_QUOTE, 1'b0));
        add_row(byte_row(CH_QUOTE, 1'b1));
        // max_len of one: second key byte dropped, value cut short.
        add_row(cfg_row(10'd1));
        add_row(byte_row(CH_QUOTE, 1'b0));
        add_row(byte_row(8'h61, 1'b0));
        add_row(byte_row(8'h62, 1'b0));
        add_row(byte_row(CH_QUOTE, 1'b0));
        add_row(byte_row(8'h3D, 1'b0));
        add_row(byte_row(CH_QUOTE, 1'b0));
        add_row(byte_row(8'h63, 1'b1));

        foreach (stim_rows[i])
        begin
            if (stim_rows[i].op == ROW_CFG)
                write_max_len(stim_rows[i].cfg_val);
            else
                send_byte(stim_rows[i].text_byte, stim_rows[i].last,
                          stim_rows[i].typed, stim_rows[i].want);
        end

        // Random part: one max_len per phase, the idle pattern rotating
        // through none / sender / receiver / both.
        len_plan = '{10'd3, LEN_MAX_RESET_VAL(), 10'd1, 10'd0,
                     10'd16, 10'd0, 10'd2, MAX_LEN_RESET};
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            next_len = (ph == 5) ? LEN_W'($urandom_range(1022, 2)) : len_plan[ph];
            write_max_len(next_len);
            case (ph % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 79;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 79;
                end
                default:
                begin
                    send_idle_pct  = 13;
                    recv_stall_pct = 13;
                end
            endcase
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                // one oversized key at the widest setting, to reach the cap
                send_random_literal(ph == 1 && phase_items == 0, sent);
                phase_items += sent;
            end
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && decoded_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
